// ===== sv/assert_macros.svh =====
// assertion helpers used by keypad_lock_controller_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ===== sv/klc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// klc_pkg
// Types and constants for the keypad lock controller: item kinds, event codes,
// configuration register indexes, reset values and the lock state record.
// ----------------------------------------------------------------------------
package klc_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_FIRST     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_SECOND    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_THIRD     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_FOURTH    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELOCK_TICKS   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DOOR_THRESHOLD = 3'd5;

    // field widths
    localparam int DIGIT_W     = 4;
    localparam int SAMPLE_W    = 12;
    localparam int TICKS_W     = 8;
    localparam int CFG_DIGITS  = 4;

    // reset values, also the value of code digits past the fourth
    localparam logic [DIGIT_W-1:0]  CODE_DIGIT_RESET     = 4'd5;
    localparam logic [TICKS_W-1:0]  RELOCK_TICKS_RESET   = 8'd10;
    localparam logic [SAMPLE_W-1:0] DOOR_THRESHOLD_RESET = 12'd50;

    // item kind carried on tuser
    typedef enum logic [1:0] {
        MODE_KEY  = 2'd0,
        MODE_DOOR = 2'd1,
        MODE_TICK = 2'd2
    } mode_t;

    // event reported with each result
    typedef enum logic [3:0] {
        EV_NONE         = 4'd0,
        EV_DIGIT_TAKEN  = 4'd1,
        EV_UNLOCKED     = 4'd2,
        EV_ALREADY_OPEN = 4'd3,
        EV_REJECTED     = 4'd4,
        EV_DOOR_OPENED  = 4'd5,
        EV_DOOR_LOCKED  = 4'd6,
        EV_TIMER_RELOCK = 4'd7,
        EV_TIMER_DOOR   = 4'd8
    } event_t;

    // lock, door and relock timer state
    typedef struct packed {
        logic               lock_open;
        logic               door_open;
        logic               timer_running;
        logic [TICKS_W-1:0] relock_count;
    } lock_state_t;

endpackage
`default_nettype wire

// ===== sv/klc_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// klc_step
// Next-state logic for one item: digit entry and code check, door sample
// against the threshold, and relock countdown tick.
// ----------------------------------------------------------------------------
module klc_step #(
    parameter int CODE_LENGTH = 4,
    parameter int KEY_COUNT   = 9,
    parameter int CNT_W       = 2
) (
    input  wire logic [1:0]                       mode,
    input  wire logic [klc_pkg::DIGIT_W-1:0]      key,
    input  wire logic [klc_pkg::SAMPLE_W-1:0]     sample,
    input  wire logic [klc_pkg::DIGIT_W-1:0]      code_digit [klc_pkg::CFG_DIGITS],
    input  wire logic [klc_pkg::TICKS_W-1:0]      relock_ticks,
    input  wire logic [klc_pkg::SAMPLE_W-1:0]     door_threshold,
    input  wire klc_pkg::lock_state_t             state_cur,
    input  wire logic [CNT_W-1:0]                 digit_cnt,
    input  wire logic [klc_pkg::DIGIT_W-1:0]      digit_store [CODE_LENGTH],
    output klc_pkg::lock_state_t                  state_new,
    output logic [CNT_W-1:0]                      digit_cnt_new,
    output logic                                  store_wr_en,
    output logic [klc_pkg::DIGIT_W-1:0]           store_wr_digit,
    output klc_pkg::event_t                       event_code
);
    import klc_pkg::*;

    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(CODE_LENGTH - 1);

    logic                key_valid;
    logic                code_match;
    logic                door_high;
    logic [DIGIT_W-1:0]  expect_digit [CODE_LENGTH];
    logic [DIGIT_W-1:0]  got_digit    [CODE_LENGTH];

    // key must be below the key count; index fifteen has no digit
    assign key_valid      = ({1'b0, key} < 5'(KEY_COUNT)) && (key != 4'hF);
    assign store_wr_digit = key + 4'd1;
    assign door_high      = (sample >= door_threshold);

    // code check: stored digits plus the digit being pressed in the last place
    always_comb begin
        code_match = 1'b1;
        for (int i = 0; i < CODE_LENGTH; i++) begin
            expect_digit[i] = (i < CFG_DIGITS) ? code_digit[i % CFG_DIGITS]
                                               : CODE_DIGIT_RESET;
            got_digit[i]    = (i == CODE_LENGTH - 1) ? store_wr_digit : digit_store[i];
            if (got_digit[i] != expect_digit[i]) begin
                code_match = 1'b0;
            end
        end
    end

    // per-kind state update and event
    always_comb begin
        state_new     = state_cur;
        digit_cnt_new = digit_cnt;
        store_wr_en   = 1'b0;
        event_code    = EV_NONE;
        case (mode)
            MODE_KEY: begin
                if (key_valid) begin
                    store_wr_en = 1'b1;
                    if (digit_cnt != LAST_POS) begin
                        digit_cnt_new = digit_cnt + 1'b1;
                        event_code    = EV_DIGIT_TAKEN;
                    end else begin
                        digit_cnt_new = '0;
                        if (!code_match) begin
                            event_code = EV_REJECTED;
                        end else if (state_cur.lock_open) begin
                            event_code = EV_ALREADY_OPEN;
                        end else begin
                            state_new.lock_open     = 1'b1;
                            state_new.relock_count  = relock_ticks;
                            state_new.timer_running = 1'b1;
                            event_code              = EV_UNLOCKED;
                        end
                    end
                end
            end
            MODE_DOOR: begin
                if (door_high) begin
                    if (!state_cur.door_open) begin
                        state_new.door_open = 1'b1;
                        event_code          = EV_DOOR_OPENED;
                    end
                end else if (state_cur.door_open) begin
                    state_new.door_open = 1'b0;
                    state_new.lock_open = 1'b0;
                    event_code          = EV_DOOR_LOCKED;
                end
            end
            MODE_TICK: begin
                if (state_cur.timer_running) begin
                    if (state_cur.relock_count > 8'd1) begin
                        state_new.relock_count = state_cur.relock_count - 8'd1;
                    end else begin
                        state_new.relock_count  = '0;
                        state_new.timer_running = 1'b0;
                        if (state_cur.door_open) begin
                            event_code = EV_TIMER_DOOR;
                        end else if (state_cur.lock_open) begin
                            state_new.lock_open = 1'b0;
                            event_code          = EV_TIMER_RELOCK;
                        end
                    end
                end
            end
            default: begin
                event_code = EV_NONE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/keypad_lock_controller_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// keypad_lock_controller_unit
// Combination lock: key presses build a code, door samples track the door,
// timer ticks count down to an automatic relock.
// ----------------------------------------------------------------------------
// Usage
//   Input stream s_*: tuser carries the item kind (key press, door sample,
//   timer tick), tdata the key index and the door sensor reading.
//   Output stream m_*: one result per input item, in order, with lock state,
//   door state, event code and the number of digits held.
//   Configuration: cfg_wr_en/cfg_wr_index/cfg_wr_data write the four code
//   digits, the relock length and the door threshold; write only while idle.
//   Pipeline: two register stages; the item lands in the input register when
//   it transfers, and the single-pass update loads the result register from
//   it once the result stage is free, raising m_tvalid.
//   Throughput: one item per cycle while m_tready stays high; the state
//   update is one short combinational pass.
//   Reset: aresetn low clears both stages, the lock and door state, the
//   timer and the digit count, and loads the default configuration.
//   Stall: while m_tready is low the result holds; the input register still
//   takes one more item, then s_tready drops until the result leaves.
// ----------------------------------------------------------------------------
module keypad_lock_controller_unit #(
    parameter int CODE_LENGTH = 4,
    parameter int KEY_COUNT   = 9
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [15:0]                       s_tdata,  // key[3:0], sample[15:4]
    input  wire logic [1:0]                        s_tuser,  // mode[1:0]
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [7:0]                             m_tdata,  // lock_open[0],
                                                             // door_open[1],
                                                             // event_res[5:2],
                                                             // digits_entered[7:6]
    // configuration writes
    input  wire logic                              cfg_wr_en,
    input  wire logic [klc_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  wire logic [klc_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import klc_pkg::*;

    localparam int CNT_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    // configuration registers
    logic [DIGIT_W-1:0]  code_digit_reg [CFG_DIGITS];
    logic [TICKS_W-1:0]  relock_ticks_reg;
    logic [SAMPLE_W-1:0] door_threshold_reg;

    // input stage
    logic                in_valid_reg;
    logic [1:0]          in_mode_reg;
    logic [DIGIT_W-1:0]  in_key_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;

    // block state
    lock_state_t         state_reg;
    lock_state_t         state_next;
    logic [CNT_W-1:0]    digit_cnt_reg;
    logic [CNT_W-1:0]    digit_cnt_next;
    logic [DIGIT_W-1:0]  digit_store_reg [CODE_LENGTH];

    // result stage
    logic                out_valid_reg;
    logic [7:0]          out_data_reg;
    logic [7:0]          out_data_next;

    logic                out_ready;
    logic                advance;
    logic                in_take;
    logic                store_wr_en;
    logic [DIGIT_W-1:0]  store_wr_digit;
    event_t              step_event;
    logic [CNT_W+1:0]    cnt_ext;

    // handshake: result stage frees up when empty or taken
    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign in_take   = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // configuration register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CFG_DIGITS; i++) begin
                code_digit_reg[i] <= CODE_DIGIT_RESET;
            end
            relock_ticks_reg   <= RELOCK_TICKS_RESET;
            door_threshold_reg <= DOOR_THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_CODE_FIRST:     code_digit_reg[0]  <= cfg_wr_data[DIGIT_W-1:0];
                CFG_CODE_SECOND:    code_digit_reg[1]  <= cfg_wr_data[DIGIT_W-1:0];
                CFG_CODE_THIRD:     code_digit_reg[2]  <= cfg_wr_data[DIGIT_W-1:0];
                CFG_CODE_FOURTH:    code_digit_reg[3]  <= cfg_wr_data[DIGIT_W-1:0];
                CFG_RELOCK_TICKS:   relock_ticks_reg   <= cfg_wr_data[TICKS_W-1:0];
                CFG_DOOR_THRESHOLD: door_threshold_reg <= cfg_wr_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // single-pass state update
    klc_step #(
        .CODE_LENGTH (CODE_LENGTH),
        .KEY_COUNT   (KEY_COUNT),
        .CNT_W       (CNT_W)
    ) u_step (
        .mode           (in_mode_reg),
        .key            (in_key_reg),
        .sample         (in_sample_reg),
        .code_digit     (code_digit_reg),
        .relock_ticks   (relock_ticks_reg),
        .door_threshold (door_threshold_reg),
        .state_cur      (state_reg),
        .digit_cnt      (digit_cnt_reg),
        .digit_store    (digit_store_reg),
        .state_new      (state_next),
        .digit_cnt_new  (digit_cnt_next),
        .store_wr_en    (store_wr_en),
        .store_wr_digit (store_wr_digit),
        .event_code     (step_event)
    );

    // pack the result from the updated state
    assign cnt_ext       = {2'b00, digit_cnt_next};
    assign out_data_next = {cnt_ext[1:0], step_event, state_next.door_open,
                            state_next.lock_open};

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            digit_cnt_reg <= '0;
        end else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
                digit_cnt_reg <= digit_cnt_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_mode_reg   <= s_tuser;
            in_key_reg    <= s_tdata[DIGIT_W-1:0];
            in_sample_reg <= s_tdata[DIGIT_W+SAMPLE_W-1:DIGIT_W];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
        if (advance && store_wr_en) begin
            digit_store_reg[digit_cnt_reg] <= store_wr_digit;
        end
    end

    // checks
    `ASSERT_IMPLY(a_timer_idle_zero, aclk, aresetn,
        !state_reg.timer_running, state_reg.relock_count == '0)
    `ASSERT_IMPLY(a_cnt_in_range, aclk, aresetn,
        1'b1, digit_cnt_reg <= CNT_W'(CODE_LENGTH - 1))
    `ASSERT_NEXT(a_unlock_arms, aclk, aresetn,
        advance && (step_event == EV_UNLOCKED),
        state_reg.lock_open && state_reg.timer_running)

endmodule
`default_nettype wire

// ===== sim/keypad_lock_controller_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_lock_controller_unit_tb
// Streams key presses, door samples, timer ticks and unused kinds into the
// lock controller under several code, relock and threshold settings. A local
// lock model predicts every result, and the monitor checks each result
// transfer against the oldest prediction while both stream sides idle and
// stall at random.
// ----------------------------------------------------------------------------
module keypad_lock_controller_unit_tb;
    import klc_pkg::*;

    localparam int          CODE_LEN    = 4;
    localparam int          KEY_LIMIT   = 9;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          DRAIN_WAIT  = 4;

    typedef struct packed {
        logic [1:0]          mode;
        logic [3:0]          key;
        logic [SAMPLE_W-1:0] sample;
    } lock_item_t;

    typedef struct packed {
        logic       lock_open;
        logic       door_open;
        logic [3:0] ev;
        logic [1:0] digits;
    } lock_result_t;

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   s_tvalid     = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata      = '0;
    logic [1:0]             s_tuser      = '0;
    logic                   m_tvalid;
    logic                   m_tready     = 1'b0;
    logic [7:0]             m_tdata;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data  = '0;

    // items waiting to be offered, results still owed by the block
    lock_item_t   pending_items[$];
    lock_result_t lock_expect_q[$];
    lock_item_t   offered_item;

    // configuration shadow
    logic [DIGIT_W-1:0]  code_cfg[CODE_LEN];
    logic [TICKS_W-1:0]  relock_cfg;
    logic [SAMPLE_W-1:0] thresh_cfg;

    // lock model state
    logic [DIGIT_W-1:0] entered[CODE_LEN];
    int                 digit_cnt;
    logic               lock_st;
    logic               door_st;
    logic [TICKS_W-1:0] relock_left;
    logic               timer_on;

    int   errors       = 0;
    int   results_seen = 0;
    int   items_made   = 0;
    int   gen_digits   = 0;
    int   cycles       = 0;
    logic no_idle      = 1'b0;

    keypad_lock_controller_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // next result of the lock for one item, advances the model state
    function automatic lock_result_t predict_lock(input lock_item_t it);
        lock_result_t r;
        logic [3:0]   ev;
        logic         match;
        int           i;
        ev = EV_NONE;
        case (it.mode)
            MODE_KEY: begin
                if (it.key < KEY_LIMIT) begin
                    entered[digit_cnt] = it.key + 4'd1;
                    digit_cnt++;
                    if (digit_cnt < CODE_LEN) begin
                        ev = EV_DIGIT_TAKEN;
                    end else begin
                        digit_cnt = 0;
                        match = 1'b1;
                        for (i = 0; i < CODE_LEN; i++) begin
                            if (entered[i] != code_cfg[i]) match = 1'b0;
                        end
                        if (!match) begin
                            ev = EV_REJECTED;
                        end else if (lock_st) begin
                            ev = EV_ALREADY_OPEN;
                        end else begin
                            lock_st     = 1'b1;
                            relock_left = relock_cfg;
                            timer_on    = 1'b1;
                            ev          = EV_UNLOCKED;
                        end
                    end
                end
            end
            MODE_DOOR: begin
                if (it.sample >= thresh_cfg) begin
                    if (!door_st) begin
                        door_st = 1'b1;
                        ev      = EV_DOOR_OPENED;
                    end
                end else if (door_st) begin
                    // closing transition always locks, countdown keeps going
                    door_st = 1'b0;
                    lock_st = 1'b0;
                    ev      = EV_DOOR_LOCKED;
                end
            end
            MODE_TICK: begin
                if (timer_on) begin
                    if (relock_left > 1) begin
                        relock_left--;
                    end else begin
                        relock_left = '0;
                        timer_on    = 1'b0;
                        if (door_st) begin
                            ev = EV_TIMER_DOOR;
                        end else if (lock_st) begin
                            lock_st = 1'b0;
                            ev      = EV_TIMER_RELOCK;
                        end
                    end
                end
            end
            default: ev = EV_NONE;
        endcase
        r.lock_open = lock_st;
        r.door_open = door_st;
        r.ev        = ev;
        r.digits    = digit_cnt[1:0];
        return r;
    endfunction

    // input driver: bursts with random gaps, holds the item while stalled
    int burst_left = 0;
    int gap_left   = 0;
    always @(posedge aclk) begin
        logic       nv;
        lock_item_t nx;
        nv = 1'b0;
        nx = offered_item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                lock_expect_q.push_back(predict_lock(offered_item));
            end
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0 && !no_idle) begin
                    gap_left--;
                end else if (pending_items.size() > 0) begin
                    nx = pending_items.pop_front();
                    nv = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                offered_item <= nx;
                s_tvalid     <= nv;
                s_tdata      <= {nx.sample, nx.key};
                s_tuser      <= nx.mode;
            end
        end
    end

    // receiver ready: changing stall style, one long hold-off
    int   hold_left  = 0;
    int   style_cnt  = 0;
    int   stall_kind = 0;
    logic long_done  = 1'b0;
    always @(posedge aclk) begin
        logic rdy;
        rdy = 1'b1;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            style_cnt++;
            if (style_cnt % 128 == 0) stall_kind = $urandom_range(0, 2);
            if (!long_done && results_seen >= 300) begin
                hold_left = 80;
                long_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!no_idle) begin
                case (stall_kind)
                    1:       rdy = ($urandom_range(0, 9) >= 4);
                    2:       rdy = ((style_cnt % 5) >= 2);
                    default: rdy = 1'b1;
                endcase
            end
            m_tready <= rdy;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        lock_result_t want;
        lock_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            got = {m_tdata[0], m_tdata[1], m_tdata[5:2], m_tdata[7:6]};
            if (lock_expect_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result lock=%0d door=%0d ev=%0d digits=%0d",
                             got.lock_open, got.door_open, got.ev, got.digits);
            end else begin
                want = lock_expect_q.pop_front();
                if (got.lock_open != want.lock_open || got.door_open != want.door_open ||
                    got.ev != want.ev || got.digits != want.digits) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch at result %0d: ", results_seen,
                                 "exp lock=%0d door=%0d ev=%0d digits=%0d, ",
                                 want.lock_open, want.door_open, want.ev, want.digits,
                                 "got lock=%0d door=%0d ev=%0d digits=%0d",
                                 got.lock_open, got.door_open, got.ev, got.digits);
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_item(input logic [1:0] mode, input logic [3:0] key,
                             input logic [SAMPLE_W-1:0] sample);
        lock_item_t it;
        it.mode   = mode;
        it.key    = key;
        it.sample = sample;
        pending_items.push_back(it);
        items_made++;
    endtask

    // key press, tracks where the digit count will stand
    task automatic push_key(input logic [3:0] key);
        if (key < KEY_LIMIT) gen_digits = (gen_digits + 1) % CODE_LEN;
        push_item(MODE_KEY, key, $urandom_range(0, 4095));
    endtask

    task automatic push_door(input logic [SAMPLE_W-1:0] sample);
        push_item(MODE_DOOR, $urandom_range(0, 15), sample);
    endtask

    task automatic push_tick();
        push_item(MODE_TICK, $urandom_range(0, 15), $urandom_range(0, 4095));
    endtask

    // full code entry starting on a fresh digit count
    task automatic push_code(input logic wrong);
        int i;
        int bad;
        while (gen_digits != 0) push_key($urandom_range(0, KEY_LIMIT - 1));
        bad = $urandom_range(0, CODE_LEN - 1);
        for (i = 0; i < CODE_LEN; i++) begin
            if (wrong && i == bad)
                push_key($urandom_range(0, KEY_LIMIT - 1));
            else
                push_key(code_cfg[i] - 4'd1);
        end
    endtask

    // mostly code entries, door traffic around the threshold and tick runs
    task automatic push_random(input int count);
        int target;
        int sel;
        int n;
        int i;
        target = items_made + count;
        while (items_made < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                push_code(1'b0);
            end else if (sel < 50) begin
                push_code(1'b1);
            end else if (sel < 68) begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++) begin
                    case ($urandom_range(0, 3))
                        0:       push_door(thresh_cfg - 1);
                        1:       push_door(thresh_cfg);
                        2:       push_door(thresh_cfg + 1);
                        default: push_door($urandom_range(0, 4095));
                    endcase
                end
            end else if (sel < 88) begin
                n = ($urandom_range(0, 3) == 0) ? relock_cfg + 1 : $urandom_range(1, 4);
                if (n > 40) n = 40;
                for (i = 0; i < n; i++) push_tick();
            end else begin
                case ($urandom_range(0, 2))
                    0:       push_key($urandom_range(KEY_LIMIT, 15));
                    1:       push_item(MODE_UNUSED, $urandom_range(0, 15),
                                       $urandom_range(0, 4095));
                    default: push_key($urandom_range(0, KEY_LIMIT - 1));
                endcase
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        case (idx)
            CFG_CODE_FIRST, CFG_CODE_SECOND, CFG_CODE_THIRD, CFG_CODE_FOURTH:
                code_cfg[idx] = val[DIGIT_W-1:0];
            CFG_RELOCK_TICKS:   relock_cfg = val[TICKS_W-1:0];
            CFG_DOOR_THRESHOLD: thresh_cfg = val[SAMPLE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int c0, input int c1, input int c2, input int c3,
                              input int relock, input int thresh);
        write_reg(CFG_CODE_FIRST, c0);
        write_reg(CFG_CODE_SECOND, c1);
        write_reg(CFG_CODE_THIRD, c2);
        write_reg(CFG_CODE_FOURTH, c3);
        write_reg(CFG_RELOCK_TICKS, relock);
        write_reg(CFG_DOOR_THRESHOLD, thresh);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // sender pauses until every owed result is back
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || lock_expect_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // stimulus phases
    initial begin
        int i;
        for (i = 0; i < CODE_LEN; i++) begin
            code_cfg[i] = CODE_DIGIT_RESET;
            entered[i]  = '0;
        end
        relock_cfg  = RELOCK_TICKS_RESET;
        thresh_cfg  = DOOR_THRESHOLD_RESET;
        digit_cnt   = 0;
        lock_st     = 1'b0;
        door_st     = 1'b0;
        relock_left = '0;
        timer_on    = 1'b0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: tick while stopped, unlock, reopen, ignored kinds,
        // door edges at the threshold, rejected code
        push_tick();
        push_code(1'b0);
        push_key(4'd15);
        push_key(4'd9);
        push_item(MODE_UNUSED, 4'hf, 12'hfff);
        push_code(1'b0);
        push_door(12'd50);
        push_door(12'd4095);
        push_door(12'd49);
        push_key(4'd0);
        push_key(4'd8);
        push_key(4'd4);
        push_key(4'd4);
        push_door(12'd0);
        push_random(100);
        wait_drained();

        // threshold zero keeps the door open, one-tick relock expires on it
        set_config(1, 9, 1, 9, 1, 0);
        push_code(1'b0);
        push_door(12'd0);
        push_tick();
        push_random(80);
        wait_drained();

        // top threshold and longest countdown, one run to expiry
        set_config(9, 9, 9, 9, 255, 4095);
        push_door(12'd4095);
        push_door(12'd4094);
        push_random(40);
        push_code(1'b0);
        for (i = 0; i < 256; i++) push_tick();
        wait_drained();

        // zero relock length expires on the next tick
        set_config(3, 7, 2, 6, 0, 2048);
        push_code(1'b0);
        push_tick();
        push_random(80);
        wait_drained();

        // random settings with neither side idling
        set_config($urandom_range(1, 9), $urandom_range(1, 9), $urandom_range(1, 9),
                   $urandom_range(1, 9), $urandom_range(1, 20), $urandom_range(0, 4095));
        no_idle = 1'b1;
        push_random(80);
        wait_drained();
        no_idle = 1'b0;

        // random settings with idling back on
        set_config($urandom_range(1, 9), $urandom_range(1, 9), $urandom_range(1, 9),
                   $urandom_range(1, 9), $urandom_range(0, 255), $urandom_range(0, 4095));
        push_random(70);
        wait_drained();

        repeat (10) @(posedge aclk);
        if (lock_expect_q.size() != 0) errors++;
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/klc_pkg.sv
sv/klc_step.sv
sv/keypad_lock_controller_unit.sv
sim/keypad_lock_controller_unit_tb.sv
